FILE: rtl/orse_pkg.sv
// shared types, codes and constants of the 1-wire rom search engine
package orse_pkg;

  // search geometry
  localparam int unsigned ROM_BITS_DEF  = 64;
  localparam int unsigned ADDR_W        = 64;
  localparam int unsigned IDX_W         = 7;
  localparam int unsigned THRESH_W      = 15;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 15'd15;

  // request queue between front and back
  localparam int unsigned QUEUE_DEPTH   = 2;

  // result buffer, power of two depth
  localparam int unsigned OUT_DEPTH     = 4;
  localparam int unsigned OUT_PTR_W     = $clog2(OUT_DEPTH);
  localparam int unsigned OUT_CNT_W     = $clog2(OUT_DEPTH + 1);

  // stream widths
  localparam int unsigned S_TDATA_W     = 16;
  localparam int unsigned S_TUSER_W     = 2;
  localparam int unsigned M_TDATA_W     = 72;
  localparam int unsigned M_TUSER_W     = 2;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_BEGIN  = 2'd1,
    OP_SAMPLE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_BEGIN  = 2'd1,
    CMD_SAMPLE = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_WRITE     = 2'd0,
    KIND_DONE      = 2'd1,
    KIND_ABORT     = 2'd2,
    KIND_EXHAUSTED = 2'd3
  } kind_e;

  typedef struct packed {
    cmd_e cmd;
    logic sample_bit;
  } cmd_t;

  typedef struct packed {
    kind_e             kind;
    logic              write_bit;
    logic [ADDR_W-1:0] rom_address;
    logic              last;
  } result_t;

endpackage

FILE: rtl/orse_front.sv
// front end: takes requests, decodes the read slot bit, feeds the queue
module orse_front import orse_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [THRESH_W-1:0]  cfg_wdata_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  input  logic [S_TUSER_W-1:0] s_axis_tuser,
  input  logic                 queue_full_i,
  output logic                 push_o,
  output cmd_t                 push_data_o
);

  logic [THRESH_W-1:0] threshold_q;
  logic [THRESH_W-1:0] low_time;
  logic                present;
  logic                known;
  op_e                 op;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= THRESH_RESET;
    end else if (cfg_we_i) begin
      threshold_q <= cfg_wdata_i;
    end
  end

  assign low_time      = s_axis_tdata[THRESH_W-1:0];
  assign present       = s_axis_tdata[THRESH_W];
  assign op            = op_e'(s_axis_tuser);
  assign s_axis_tready = !queue_full_i;

  always_comb begin
    known                  = 1'b1;
    push_data_o.cmd        = CMD_CLEAR;
    // a timed out slot reads as zero
    push_data_o.sample_bit = present && (low_time <= threshold_q);
    unique case (op)
      OP_CLEAR:  push_data_o.cmd = CMD_CLEAR;
      OP_BEGIN:  push_data_o.cmd = CMD_BEGIN;
      OP_SAMPLE: push_data_o.cmd = CMD_SAMPLE;
      default:   known = 1'b0;
    endcase
  end

  // unused opcode is dropped here
  assign push_o = s_axis_tvalid && s_axis_tready && known;

endmodule

FILE: rtl/orse_queue.sv
// short request queue between front and back
module orse_queue import orse_pkg::*; #(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t pop_data_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/orse_back.sv
// back end: search state update and result buffer
module orse_back import orse_pkg::*; #(
  parameter int unsigned RomBits = ROM_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 queue_empty_i,
  input  cmd_t                 cmd_i,
  output logic                 pop_o,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  output logic [M_TUSER_W-1:0] m_axis_tuser,
  output logic                 m_axis_tlast
);

  localparam int unsigned BitW = $clog2(RomBits);
  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(RomBits);

  // search state
  logic [RomBits-1:0] saved_addr_q, saved_addr_d;
  logic [RomBits-1:0] work_addr_q, work_addr_d;
  logic [IDX_W-1:0]   disc_q, disc_d;
  logic [IDX_W-1:0]   newest_zero_q, newest_zero_d;
  logic [IDX_W-1:0]   bit_index_q, bit_index_d;
  logic               exhausted_q, exhausted_d;
  logic               awaiting_q, awaiting_d;
  logic               first_bit_q, first_bit_d;
  logic               pass_active_q, pass_active_d;

  // result buffer
  result_t              res_q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [OUT_CNT_W-1:0] cnt_q;

  logic             fire, out_pop, done_push;
  logic [1:0]       n_push;
  result_t          r0, r1;
  logic [IDX_W-1:0] cur_idx, bit_off;
  logic             branch, final_pair;
  result_t          head;

  // a request runs only when two result slots are free
  assign fire    = !queue_empty_i && (cnt_q <= OUT_CNT_W'(OUT_DEPTH - 2));
  assign pop_o   = fire;
  assign out_pop = m_axis_tvalid && m_axis_tready;

  assign cur_idx = ((bit_index_q == '0) || (bit_index_q > LastIdx)) ? IDX_W'(1) : bit_index_q;
  assign bit_off = cur_idx - IDX_W'(1);
  assign final_pair = (cur_idx == LastIdx);

  always_comb begin
    saved_addr_d  = saved_addr_q;
    work_addr_d   = work_addr_q;
    disc_d        = disc_q;
    newest_zero_d = newest_zero_q;
    bit_index_d   = bit_index_q;
    exhausted_d   = exhausted_q;
    awaiting_d    = awaiting_q;
    first_bit_d   = first_bit_q;
    pass_active_d = pass_active_q;
    n_push        = 2'd0;
    r0            = '0;
    r1            = '0;
    branch        = 1'b0;
    done_push     = 1'b0;
    if (fire) begin
      unique case (cmd_i.cmd)
        CMD_CLEAR: begin
          saved_addr_d  = '0;
          work_addr_d   = '0;
          disc_d        = '0;
          newest_zero_d = '0;
          bit_index_d   = IDX_W'(1);
          exhausted_d   = 1'b0;
          awaiting_d    = 1'b0;
          first_bit_d   = 1'b0;
          pass_active_d = 1'b0;
        end
        CMD_BEGIN: begin
          if (exhausted_q) begin
            pass_active_d = 1'b0;
            n_push        = 2'd1;
            r0.kind       = KIND_EXHAUSTED;
            r0.last       = 1'b1;
          end else begin
            pass_active_d = 1'b1;
            work_addr_d   = saved_addr_q;
            newest_zero_d = '0;
            bit_index_d   = IDX_W'(1);
            awaiting_d    = 1'b0;
            first_bit_d   = 1'b0;
          end
        end
        CMD_SAMPLE: begin
          if (pass_active_q) begin
            if (!awaiting_q) begin
              first_bit_d = cmd_i.sample_bit;
              awaiting_d  = 1'b1;
            end else if (first_bit_q && cmd_i.sample_bit) begin
              // no device answered the pair
              awaiting_d    = 1'b0;
              pass_active_d = 1'b0;
              n_push        = 2'd1;
              r0.kind       = KIND_ABORT;
              r0.last       = 1'b1;
            end else begin
              awaiting_d  = 1'b0;
              bit_index_d = cur_idx;
              if (first_bit_q != cmd_i.sample_bit) begin
                branch = first_bit_q;
              end else begin
                // discrepancy: follow previous path below the mark, take one at it, zero above it
                if (cur_idx < disc_q) begin
                  branch = work_addr_q[bit_off[BitW-1:0]];
                end else begin
                  branch = (cur_idx == disc_q);
                end
                if (!branch) begin
                  newest_zero_d = cur_idx;
                end
              end
              work_addr_d[bit_off[BitW-1:0]] = branch;
              n_push       = 2'd1;
              r0.kind      = KIND_WRITE;
              r0.write_bit = branch;
              r0.last      = !final_pair;
              if (final_pair) begin
                disc_d         = newest_zero_d;
                exhausted_d    = exhausted_q || (newest_zero_d == '0);
                saved_addr_d   = work_addr_d;
                pass_active_d  = 1'b0;
                bit_index_d    = IDX_W'(1);
                n_push         = 2'd2;
                done_push      = 1'b1;
                r1.kind        = KIND_DONE;
                r1.rom_address = ADDR_W'(work_addr_d);
                r1.last        = 1'b1;
              end else begin
                bit_index_d = cur_idx + IDX_W'(1);
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      saved_addr_q  <= '0;
      work_addr_q   <= '0;
      disc_q        <= '0;
      newest_zero_q <= '0;
      bit_index_q   <= IDX_W'(1);
      exhausted_q   <= 1'b0;
      awaiting_q    <= 1'b0;
      first_bit_q   <= 1'b0;
      pass_active_q <= 1'b0;
    end else begin
      saved_addr_q  <= saved_addr_d;
      work_addr_q   <= work_addr_d;
      disc_q        <= disc_d;
      newest_zero_q <= newest_zero_d;
      bit_index_q   <= bit_index_d;
      exhausted_q   <= exhausted_d;
      awaiting_q    <= awaiting_d;
      first_bit_q   <= first_bit_d;
      pass_active_q <= pass_active_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      res_q[wr_ptr_q] <= r0;
    end
    if (n_push == 2'd2) begin
      res_q[wr_ptr_q + 1'b1] <= r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + OUT_PTR_W'(n_push);
      if (out_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + OUT_CNT_W'(n_push) - OUT_CNT_W'(out_pop);
    end
  end

  assign head          = res_q[rd_ptr_q];
  assign m_axis_tvalid = (cnt_q != '0);
  assign m_axis_tdata  = {7'd0, head.rom_address, head.write_bit};
  assign m_axis_tuser  = head.kind;
  assign m_axis_tlast  = head.last;

  a_out_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= OUT_CNT_W'(OUT_DEPTH))
    else $error("result buffer overflow");

  a_idle_no_pair : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pass_active_q |-> !awaiting_q)
    else $error("half pair held with no pass running");

  a_done_ends_pass : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_push |=> !pass_active_q && (bit_index_q == IDX_W'(1)))
    else $error("pass still running after final pair");

  a_done_exhaust : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_push |=> exhausted_q == ($past(exhausted_q) || (disc_q == '0)))
    else $error("exhausted flag out of step with saved discrepancy");

endmodule

FILE: rtl/onewire_rom_search_engine.sv
// top level of the 1-wire rom search engine
// a request passes the queue register and then the result buffer before its first result shows
// one request per cycle unless stalled; a final pair yields two results, drained one per cycle
// the back end runs a request only while two result slots are free in the output buffer
// reset: asynchronous, active low; search state cleared, bit index 1, threshold 15
// no clearing pass, the block takes requests right after reset
module onewire_rom_search_engine import orse_pkg::*; #(
  parameter int unsigned ROM_BITS    = ROM_BITS_DEF,
  parameter int unsigned QUEUE_DEPTH = orse_pkg::QUEUE_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // threshold register write
  input  logic                 cfg_we_i,
  input  logic [THRESH_W-1:0]  cfg_wdata_i,
  // request channel
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,  // low_time[14:0], sample_present[15]
  input  logic [S_TUSER_W-1:0] s_axis_tuser,  // opcode[1:0]
  // result channel
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,  // write_bit[0], rom_address[64:1], zero[71:65]
  output logic [M_TUSER_W-1:0] m_axis_tuser,  // result_kind[1:0]
  output logic                 m_axis_tlast   // last_of_run
);

  logic push, pop, q_full, q_empty;
  cmd_t push_data, pop_data;

  // front: decodes opcode and slot bit against the threshold
  orse_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .queue_full_i  (q_full),
    .push_o        (push),
    .push_data_o   (push_data)
  );

  // decoupling queue, lets front and back stall on their own
  orse_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (q_empty)
  );

  // back: search algorithm and result buffer
  orse_back #(
    .RomBits (ROM_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .queue_empty_i (q_empty),
    .cmd_i         (pop_data),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
